/* hdl/fit_policy_heap_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fit policy heap allocator
// Shared implication forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_HEAP_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FPHA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FPHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fpha_pkg.sv */
// ----------------------------------------------------------------------------
// fpha_pkg
// Types, constants and helpers shared by the heap allocator modules.
// ----------------------------------------------------------------------------
package fpha_pkg;

  localparam int unsigned UNITS_MAX  = 4096;
  localparam int unsigned AW         = $clog2(UNITS_MAX);
  localparam int unsigned CW         = AW + 1;
  localparam int unsigned PW         = AW;
  localparam int unsigned HDR_SHIFT  = 4;
  localparam int unsigned BW         = 16;
  localparam int unsigned CFG_DW     = 13;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_e;

  typedef enum logic {
    CFG_FIT_POLICY  = 1'b0,
    CFG_ARENA_UNITS = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_COMMIT,
    ST_SPLIT,
    ST_MERGE,
    ST_SBEGIN,
    ST_STATS,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic          free;
    logic [PW-1:0] pay;
  } hdr_t;

  typedef struct packed {
    logic [1:0]    policy;
    logic [CW-1:0] units;
  } cfg_t;

  typedef struct packed {
    logic          valid;
    logic [CW-1:0] units;
  } fmt_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    hdr_t          wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic          status;
    logic [BW-1:0] block_address;
    logic          is_allocated;
    logic [BW-1:0] block_bytes;
    logic [BW-1:0] total_free_bytes;
    logic [BW-1:0] largest_free_bytes;
  } res_t;

  function automatic logic [BW-1:0] bytes_of(input logic [PW-1:0] units);
    return BW'({units, {HDR_SHIFT{1'b0}}});
  endfunction

endpackage

/* hdl/fpha_if.sv */
// ----------------------------------------------------------------------------
// fpha_if
// Valid/ready channels of the heap allocator: requests, responses, config.
// ----------------------------------------------------------------------------
interface fpha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] request_bytes;
  logic [15:0] address;
  modport source (output valid, opcode, request_bytes, address, input ready);
  modport sink   (input valid, opcode, request_bytes, address, output ready);
endinterface

interface fpha_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] block_address;
  logic        is_allocated;
  logic [15:0] block_bytes;
  logic [15:0] total_free_bytes;
  logic [15:0] largest_free_bytes;
  modport source (output valid, status, block_address, is_allocated, block_bytes,
                  total_free_bytes, largest_free_bytes, input ready);
  modport sink   (input valid, status, block_address, is_allocated, block_bytes,
                  total_free_bytes, largest_free_bytes, output ready);
endinterface

interface fpha_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/fpha_ram.sv */
// ----------------------------------------------------------------------------
// fpha_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fpha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/fpha_ctrl.sv */
// ----------------------------------------------------------------------------
// fpha_ctrl
// Sequencer that walks the block chain in the header RAM, commits splits and
// merges, and recomputes the free statistics.
// ----------------------------------------------------------------------------
module fpha_ctrl
  import fpha_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  fmt_t          fmt_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    opcode_i,
  input  logic [15:0]   request_bytes_i,
  input  logic [15:0]   address_i,
  output logic          idle_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output res_t          res_o,
  output mem_req_t      mem_o,
  input  hdr_t          rdata_i
);

  state_e state_q, state_d;

  logic [1:0]    op_q;
  logic [15:0]   req_q;
  logic [15:0]   addr_q;
  logic [CW-1:0] cur_q;
  logic [CW-1:0] pick_q;
  logic [PW-1:0] psz_q;
  logic          found_q;
  logic [CW-1:0] prv_q;
  logic [PW-1:0] prvsz_q;
  logic          prvfree_q;
  logic          hasprev_q;
  logic          nrd_q;
  logic          status_q;
  logic [BW-1:0] baddr_q;
  logic          isalloc_q;
  logic [BW-1:0] bbytes_q;
  logic [BW-1:0] tot_q;
  logic [BW-1:0] big_q;
  logic [BW-1:0] tacc_q;
  logic [BW-1:0] bacc_q;

  logic          accept;
  logic [CW-1:0] nxt;
  logic          walk_end;
  logic [CW-1:0] need;
  logic          match;
  logic          better;
  logic          take;
  logic [CW-1:0] unit;
  logic          hit;
  logic          split;
  logic [PW-1:0] bsz;
  logic [BW-1:0] sbytes;
  logic [BW-1:0] init_bytes;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign nxt        = cur_q + CW'(1) + CW'(rdata_i.pay);
  assign walk_end   = nxt >= cfg_i.units;
  assign need       = CW'(req_q[15:HDR_SHIFT]) + CW'(1);
  assign match      = rdata_i.free && (CW'(rdata_i.pay) >= need);
  assign unit       = CW'(addr_q[15:HDR_SHIFT]);
  assign hit        = (unit >= cur_q) && (unit < nxt);
  assign split      = CW'(psz_q) > (need + CW'(1));
  assign bsz        = (nrd_q && rdata_i.free) ? (psz_q + rdata_i.pay + PW'(1)) : psz_q;
  assign sbytes     = rdata_i.free ? bytes_of(rdata_i.pay) : '0;
  assign init_bytes = bytes_of(PW'(cfg_i.units - CW'(1)));

  always_comb begin
    priority case (cfg_i.policy)
      FIT_FIRST: better = 1'b0;
      FIT_BEST:  better = rdata_i.pay < psz_q;
      default:   better = rdata_i.pay > psz_q;
    endcase
  end
  assign take = match && (!found_q || better);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if ((opcode_i == OP_ALLOC && request_bytes_i != 16'd0) ||
              opcode_i == OP_FREE || opcode_i == OP_QUERY) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (op_q == OP_ALLOC) begin
          if (take && cfg_i.policy == FIT_FIRST) begin
            state_d = ST_COMMIT;
          end else if (walk_end) begin
            state_d = (found_q || take) ? ST_COMMIT : ST_DONE;
          end
        end else if (hit) begin
          state_d = (!rdata_i.free && op_q == OP_FREE) ? ST_MERGE : ST_DONE;
        end else if (walk_end) begin
          state_d = ST_DONE;
        end
      end
      ST_COMMIT: state_d = split ? ST_SPLIT : ST_SBEGIN;
      ST_SPLIT:  state_d = ST_SBEGIN;
      ST_MERGE:  state_d = ST_SBEGIN;
      ST_SBEGIN: state_d = ST_STATS;
      ST_STATS:  state_d = walk_end ? ST_DONE : ST_STATS;
      ST_DONE:   state_d = res_ready_i ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_o = '0;
    unique case (state_q)
      ST_INIT: begin
        mem_o.we    = 1'b1;
        mem_o.wdata = '{free: 1'b1, pay: PW'(cfg_i.units - CW'(1))};
      end
      ST_IDLE: begin
        if (fmt_i.valid) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = '{free: 1'b1, pay: PW'(fmt_i.units - CW'(1))};
        end
        mem_o.re = accept;
      end
      ST_WALK: begin
        if (op_q == OP_ALLOC) begin
          mem_o.re = !(take && cfg_i.policy == FIT_FIRST) && !walk_end;
        end else begin
          mem_o.re = !walk_end && (!hit || (!rdata_i.free && op_q == OP_FREE));
        end
        mem_o.raddr = nxt[AW-1:0];
      end
      ST_COMMIT: begin
        mem_o.we = 1'b1;
        if (split) begin
          mem_o.waddr = AW'(pick_q + CW'(1) + need);
          mem_o.wdata = '{free: 1'b1, pay: PW'(CW'(psz_q) - need - CW'(1))};
        end else begin
          mem_o.waddr = pick_q[AW-1:0];
          mem_o.wdata = '{free: 1'b0, pay: psz_q};
        end
      end
      ST_SPLIT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pick_q[AW-1:0];
        mem_o.wdata = '{free: 1'b0, pay: PW'(need)};
      end
      ST_MERGE: begin
        mem_o.we = 1'b1;
        if (hasprev_q && prvfree_q) begin
          mem_o.waddr = prv_q[AW-1:0];
          mem_o.wdata = '{free: 1'b1, pay: prvsz_q + bsz + PW'(1)};
        end else begin
          mem_o.waddr = pick_q[AW-1:0];
          mem_o.wdata = '{free: 1'b1, pay: bsz};
        end
      end
      ST_SBEGIN: mem_o.re = 1'b1;
      ST_STATS: begin
        mem_o.re    = !walk_end;
        mem_o.raddr = nxt[AW-1:0];
      end
      ST_DONE: mem_o = '0;
      default: mem_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      big_q <= '0;
    end else if (state_q == ST_INIT) begin
      tot_q <= init_bytes;
      big_q <= init_bytes;
    end else if (state_q == ST_IDLE && fmt_i.valid) begin
      tot_q <= bytes_of(PW'(fmt_i.units - CW'(1)));
      big_q <= bytes_of(PW'(fmt_i.units - CW'(1)));
    end else if (state_q == ST_STATS && walk_end) begin
      tot_q <= tacc_q + sbytes;
      big_q <= (sbytes > bacc_q) ? sbytes : bacc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_q      <= opcode_i;
          req_q     <= request_bytes_i;
          addr_q    <= address_i;
          cur_q     <= '0;
          found_q   <= 1'b0;
          hasprev_q <= 1'b0;
          status_q  <= 1'b1;
          baddr_q   <= '0;
          isalloc_q <= 1'b0;
          bbytes_q  <= '0;
        end
      end
      ST_WALK: begin
        cur_q <= nxt;
        if (op_q == OP_ALLOC) begin
          if (take) begin
            pick_q  <= cur_q;
            psz_q   <= rdata_i.pay;
            found_q <= 1'b1;
          end
        end else if (hit) begin
          pick_q <= cur_q;
          psz_q  <= rdata_i.pay;
          nrd_q  <= !walk_end;
          if (!rdata_i.free) begin
            status_q <= 1'b0;
            if (op_q == OP_QUERY) begin
              isalloc_q <= 1'b1;
              bbytes_q  <= bytes_of(rdata_i.pay);
            end
          end
        end else begin
          prv_q     <= cur_q;
          prvsz_q   <= rdata_i.pay;
          prvfree_q <= rdata_i.free;
          hasprev_q <= 1'b1;
        end
      end
      ST_COMMIT: begin
        status_q <= 1'b0;
        baddr_q  <= bytes_of(pick_q[AW-1:0]);
        bbytes_q <= split ? bytes_of(PW'(need)) : bytes_of(psz_q);
      end
      ST_SBEGIN: begin
        cur_q  <= '0;
        tacc_q <= '0;
        bacc_q <= '0;
      end
      ST_STATS: begin
        cur_q  <= nxt;
        tacc_q <= tacc_q + sbytes;
        bacc_q <= (sbytes > bacc_q) ? sbytes : bacc_q;
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o = '{status: status_q, block_address: baddr_q, is_allocated: isalloc_q,
                   block_bytes: bbytes_q, total_free_bytes: tot_q,
                   largest_free_bytes: big_q};

endmodule

/* hdl/fit_policy_heap_allocator.sv */
// ----------------------------------------------------------------------------
// fit_policy_heap_allocator
// Heap allocator over a chain of 16-byte-unit blocks held in a header RAM.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. An allocate, free or query walks the
// block chain from unit 0 through the header RAM at one block per cycle; an
// allocate or free that changes the chain then walks it once more to
// recompute the free totals. A failed request or a zero-byte allocate ends
// after the first walk or at once. After reset the block writes the first
// header before it takes a transaction. A result waits in an output
// register, so the next request can start while it is pending.
module fit_policy_heap_allocator
  import fpha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fpha_req_if.sink   req_i,
  fpha_rsp_if.source rsp_o,
  fpha_cfg_if.sink   cfg_i
);

  cfg_t          cfg_q;
  fmt_t          fmt;
  logic [CW-1:0] units_sat;
  logic          cfg_acc;
  logic          idle;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_q;
  logic          out_valid_q;
  mem_req_t      mem;
  hdr_t          rdata;

  assign cfg_i.ready = idle;
  assign cfg_acc     = cfg_i.valid && idle;

  always_comb begin
    if (cfg_i.data < CFG_DW'(2)) begin
      units_sat = CW'(2);
    end else if (cfg_i.data > CFG_DW'(UNITS_MAX)) begin
      units_sat = CW'(UNITS_MAX);
    end else begin
      units_sat = CW'(cfg_i.data);
    end
  end

  assign fmt.valid = cfg_acc && (cfg_i.index == CFG_ARENA_UNITS);
  assign fmt.units = units_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy <= FIT_FIRST;
      cfg_q.units  <= CW'(UNITS_MAX);
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        CFG_FIT_POLICY:  cfg_q.policy <= cfg_i.data[1:0];
        CFG_ARENA_UNITS: cfg_q.units  <= units_sat;
        default: begin
        end
      endcase
    end
  end

  fpha_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .fmt_i           (fmt),
    .in_valid_i      (req_i.valid),
    .in_ready_o      (req_i.ready),
    .opcode_i        (req_i.opcode),
    .request_bytes_i (req_i.request_bytes),
    .address_i       (req_i.address),
    .idle_o          (idle),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .mem_o           (mem),
    .rdata_i         (rdata)
  );

  fpha_ram #(
    .WIDTH ($bits(hdr_t)),
    .DEPTH (UNITS_MAX)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem.we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .re_i    (mem.re),
    .raddr_i (mem.raddr),
    .rdata_o (rdata)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.status             = out_q.status;
  assign rsp_o.block_address      = out_q.block_address;
  assign rsp_o.is_allocated       = out_q.is_allocated;
  assign rsp_o.block_bytes        = out_q.block_bytes;
  assign rsp_o.total_free_bytes   = out_q.total_free_bytes;
  assign rsp_o.largest_free_bytes = out_q.largest_free_bytes;

endmodule

/* hdl/fpha_checker.sv */
// ----------------------------------------------------------------------------
// fpha_checker
// Port-level checks of the heap allocator responses, bound to the top level.
// ----------------------------------------------------------------------------
`include "fit_policy_heap_allocator_macros.svh"

module fpha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        status_i,
  input logic [15:0] block_address_i,
  input logic        is_allocated_i,
  input logic [15:0] block_bytes_i,
  input logic [15:0] total_free_i,
  input logic [15:0] largest_free_i
);

  `FPHA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "Response dropped while stalled.")
  `FPHA_ASSERT_SAME(a_fail_empty, rsp_valid_i && status_i, block_address_i == 16'd0 && block_bytes_i == 16'd0 && !is_allocated_i, "Failed transaction carries data.")
  `FPHA_ASSERT_SAME(a_largest_le_total, rsp_valid_i, largest_free_i <= total_free_i, "Largest free block exceeds total free bytes.")
  `FPHA_ASSERT_SAME(a_unit_aligned, rsp_valid_i, block_address_i[3:0] == 4'd0 && block_bytes_i[3:0] == 4'd0 && total_free_i[3:0] == 4'd0, "Byte count not a multiple of the unit size.")

endmodule

bind fit_policy_heap_allocator fpha_checker u_fpha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .block_address_i (rsp_o.block_address),
  .is_allocated_i  (rsp_o.is_allocated),
  .block_bytes_i   (rsp_o.block_bytes),
  .total_free_i    (rsp_o.total_free_bytes),
  .largest_free_i  (rsp_o.largest_free_bytes)
);

/* tb/tb_fit_policy_heap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fit_policy_heap_allocator
// Drives allocate, free and query transactions into the heap allocator under
// all fit policies and several arena sizes. A behavioral model of the block
// chain predicts every response, and a checker compares each field in order.
// ----------------------------------------------------------------------------
module tb_fit_policy_heap_allocator;
  import fpha_pkg::*;

  typedef struct {
    logic        status;
    logic [15:0] block_address;
    logic        is_allocated;
    logic [15:0] block_bytes;
    logic [15:0] total_free_bytes;
    logic [15:0] largest_free_bytes;
  } alloc_rsp_t;

  logic clk_i;
  logic rst_ni;

  fpha_req_if req_if();
  fpha_rsp_if rsp_if();
  fpha_cfg_if cfg_if();

  fit_policy_heap_allocator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source),
    .cfg_i (cfg_if.sink)
  );

  int unsigned blk_pay [UNITS_MAX];
  bit          blk_free [UNITS_MAX];
  int unsigned mdl_policy;
  int unsigned mdl_units;
  int unsigned mdl_free_total;
  int unsigned mdl_free_largest;

  alloc_rsp_t  pending_rsp [$];
  int unsigned error_count;
  bit          quiet;
  logic [15:0] live_addrs [$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("** fit_policy_heap_allocator: FAILED **");
    $finish;
  end

  function automatic void format_model();
    for (int i = 0; i < UNITS_MAX; i++) begin
      blk_pay[i] = 0;
      blk_free[i] = 1'b0;
    end
    blk_pay[0] = mdl_units - 1;
    blk_free[0] = 1'b1;
  endfunction

  function automatic void refresh_totals();
    int unsigned u;
    int unsigned tot;
    int unsigned big;
    int unsigned b;
    u = 0;
    tot = 0;
    big = 0;
    while (u < mdl_units) begin
      if (blk_free[u]) begin
        b = blk_pay[u] * 16;
        tot += b;
        if (b > big) big = b;
      end
      u = u + 1 + blk_pay[u];
    end
    mdl_free_total = tot;
    mdl_free_largest = big;
  endfunction

  function automatic bit locate_block(input int unsigned addr, output int unsigned blk,
                                      output int unsigned prv, output bit has_prv);
    int unsigned u;
    int unsigned n;
    int unsigned unit;
    u = 0;
    prv = 0;
    has_prv = 1'b0;
    unit = addr / 16;
    while (u < mdl_units) begin
      n = u + 1 + blk_pay[u];
      if (unit >= u && unit < n) begin
        blk = u;
        return 1'b1;
      end
      prv = u;
      has_prv = 1'b1;
      u = n;
    end
    return 1'b0;
  endfunction

  function automatic void apply_config(input cfg_idx_e idx, input logic [12:0] data);
    int unsigned v;
    if (idx == CFG_FIT_POLICY) begin
      mdl_policy = data & 3;
    end else begin
      v = data;
      if (v < 2) v = 2;
      if (v > UNITS_MAX) v = UNITS_MAX;
      mdl_units = v;
      format_model();
      refresh_totals();
    end
  endfunction

  function automatic alloc_rsp_t heap_step(input logic [1:0] op, input logic [15:0] req,
                                           input logic [15:0] addr);
    alloc_rsp_t r;
    int unsigned need, u, pick, pick_size, s, nb, b, p, n;
    bit found, take, hp;
    r.status = 1'b1;
    r.block_address = '0;
    r.is_allocated = 1'b0;
    r.block_bytes = '0;
    if (op == OP_ALLOC) begin
      if (req != 0) begin
        need = req / 16 + 1;
        u = 0;
        pick = 0;
        pick_size = 0;
        found = 1'b0;
        while (u < mdl_units) begin
          s = blk_pay[u];
          if (blk_free[u] && s >= need) begin
            if (!found) take = 1'b1;
            else if (mdl_policy == FIT_FIRST) take = 1'b0;
            else if (mdl_policy == FIT_BEST) take = s < pick_size;
            else take = s > pick_size;
            if (take) begin
              pick = u;
              pick_size = s;
              found = 1'b1;
            end
            if (mdl_policy == FIT_FIRST) break;
          end
          u = u + 1 + blk_pay[u];
        end
        if (found) begin
          if (pick_size > need + 1) begin
            nb = pick + 1 + need;
            blk_pay[nb] = pick_size - need - 1;
            blk_free[nb] = 1'b1;
            blk_pay[pick] = need;
          end
          blk_free[pick] = 1'b0;
          r.status = 1'b0;
          r.block_address = 16'(pick * 16);
          r.block_bytes = 16'(blk_pay[pick] * 16);
        end
      end
    end else if (op == OP_FREE) begin
      if (locate_block(addr, b, p, hp) && !blk_free[b]) begin
        n = b + 1 + blk_pay[b];
        blk_free[b] = 1'b1;
        if (n < mdl_units && blk_free[n]) begin
          blk_pay[b] += blk_pay[n] + 1;
          blk_pay[n] = 0;
          blk_free[n] = 1'b0;
        end
        if (hp && blk_free[p]) begin
          blk_pay[p] += blk_pay[b] + 1;
          blk_pay[b] = 0;
          blk_free[b] = 1'b0;
        end
        r.status = 1'b0;
      end
    end else if (op == OP_QUERY) begin
      if (locate_block(addr, b, p, hp) && !blk_free[b]) begin
        r.status = 1'b0;
        r.is_allocated = 1'b1;
        r.block_bytes = 16'(blk_pay[b] * 16);
      end
    end
    refresh_totals();
    r.total_free_bytes = 16'(mdl_free_total);
    r.largest_free_bytes = 16'(mdl_free_largest);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(99) < 6) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic send_request(input logic [1:0] op, input logic [15:0] req,
                              input logic [15:0] addr);
    alloc_rsp_t r;
    idle_gap();
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.request_bytes <= req;
    req_if.address <= addr;
    do @(posedge clk_i); while (!req_if.ready);
    r = heap_step(op, req, addr);
    pending_rsp.push_back(r);
    if (op == OP_ALLOC && r.status == 1'b0) live_addrs.push_back(16'(r.block_address + 16));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic write_config(input cfg_idx_e idx, input logic [12:0] data);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_config(idx, data);
    live_addrs.delete();
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    alloc_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        error_count++;
        $display("%0t: response with none expected", $realtime);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.block_address !== want.block_address)
          report_mismatch("block_address", rsp_if.block_address, want.block_address);
        if (rsp_if.is_allocated !== want.is_allocated)
          report_mismatch("is_allocated", rsp_if.is_allocated, want.is_allocated);
        if (rsp_if.block_bytes !== want.block_bytes)
          report_mismatch("block_bytes", rsp_if.block_bytes, want.block_bytes);
        if (rsp_if.total_free_bytes !== want.total_free_bytes)
          report_mismatch("total_free_bytes", rsp_if.total_free_bytes,
                          want.total_free_bytes);
        if (rsp_if.largest_free_bytes !== want.largest_free_bytes)
          report_mismatch("largest_free_bytes", rsp_if.largest_free_bytes,
                          want.largest_free_bytes);
      end
    end
  end

  task automatic test_directed();
    write_config(CFG_ARENA_UNITS, 13'd64);
    send_request(OP_ALLOC, 16'd0, 16'd0);
    send_request(OP_ALLOC, 16'd1, 16'd0);
    send_request(OP_ALLOC, 16'd15, 16'd0);
    send_request(OP_ALLOC, 16'd16, 16'd0);
    send_request(OP_ALLOC, 16'd100, 16'd0);
    send_request(OP_ALLOC, 16'hFFFF, 16'd0);
    send_request(OP_QUERY, 16'd0, 16'd0);
    send_request(OP_QUERY, 16'd0, 16'd20);
    send_request(OP_QUERY, 16'd0, 16'hFFFF);
    send_request(OP_FREE, 16'd0, 16'd40);
    send_request(OP_FREE, 16'd0, 16'd40);
    send_request(OP_FREE, 16'd0, 16'hFFFF);
    send_request(OP_FREE, 16'd0, 16'd0);
    send_request(2'd3, 16'hFFFF, 16'hFFFF);
    send_request(OP_ALLOC, 16'd900, 16'd0);
    send_request(OP_ALLOC, 16'd30, 16'd0);
    send_request(OP_FREE, 16'd0, 16'd16);
    write_config(CFG_ARENA_UNITS, 13'd0);
    send_request(OP_ALLOC, 16'd1, 16'd0);
    send_request(OP_QUERY, 16'd0, 16'd0);
    write_config(CFG_ARENA_UNITS, 13'h1FFF);
    send_request(OP_ALLOC, 16'd65503, 16'd0);
    send_request(OP_ALLOC, 16'd32, 16'd0);
    send_request(OP_FREE, 16'd0, 16'd0);
  endtask

  task automatic test_policy(input logic [12:0] policy, input logic [12:0] units,
                             input int unsigned count);
    logic [1:0]  op;
    logic [15:0] req;
    logic [15:0] addr;
    int unsigned k;
    write_config(CFG_FIT_POLICY, policy);
    write_config(CFG_ARENA_UNITS, units);
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3 && i < count / 2);
      k = $urandom_range(99);
      req = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
      addr = 16'($urandom);
      if (k < 45) begin
        op = OP_ALLOC;
      end else if (k < 75 && live_addrs.size() != 0) begin
        op = OP_FREE;
        k = $urandom_range(live_addrs.size() - 1);
        addr = live_addrs[k] + 16'($urandom_range(0, 15));
        live_addrs.delete(k);
      end else if (k < 88 && live_addrs.size() != 0) begin
        op = OP_QUERY;
        addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
      end else begin
        op = 2'($urandom);
        if ($urandom_range(1) == 0) addr = 16'($urandom_range(0, units * 16));
      end
      send_request(op, req, addr);
    end
    quiet = 1'b0;
  endtask

  initial begin
    error_count = 0;
    quiet = 1'b0;
    mdl_policy = FIT_FIRST;
    mdl_units = UNITS_MAX;
    format_model();
    refresh_totals();
    req_if.valid = 1'b0;
    req_if.opcode = OP_ALLOC;
    req_if.request_bytes = '0;
    req_if.address = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FIT_POLICY;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    send_request(OP_ALLOC, 16'd64, 16'd0);
    send_request(OP_QUERY, 16'd0, 16'd16);
    test_directed();
    test_policy(FIT_FIRST, 13'd128, 230);
    test_policy(FIT_BEST, 13'd96, 230);
    test_policy(FIT_WORST, 13'd160, 230);
    test_policy(13'd3, 13'd2, 40);
    test_policy(FIT_BEST, 13'd4096, 200);
    wait_drained();
    if (error_count == 0) begin
      $display("** fit_policy_heap_allocator: PASSED **");
    end else begin
      $display("** fit_policy_heap_allocator: FAILED **");
    end
    $finish;
  end

endmodule
